// File: design/wbc_pkg.sv
// Shared types, sizes and codes of the word-break way counter.
`default_nettype none

package wbc_pkg;

  localparam int MAX_PATTERNS    = 64;
  localparam int MAX_PATTERN_LEN = 8;
  localparam int MAX_DESIGN_LEN  = 64;

  localparam int CNT_W  = $clog2(MAX_PATTERNS + 1);
  localparam int ADDR_W = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
  localparam int LIDX_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int DLEN_W = $clog2(MAX_DESIGN_LEN + 1);
  localparam int CMP_W  = (LEN_W > DLEN_W) ? LEN_W : DLEN_W;
  localparam int WAY_W  = 63;
  localparam int TOT_W  = 32;

  typedef enum logic [1:0] {
    CMD_PATTERN = 2'd0,
    CMD_DESIGN  = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DUP
  } state_t;

  typedef logic [7:0]                   char_t;
  typedef char_t [MAX_PATTERN_LEN-1:0]  chars_t;
  typedef logic [WAY_W-1:0]             way_t;
  typedef way_t [MAX_PATTERN_LEN-1:0]   hist_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [WAY_W-1:0] way_count;
    logic             possible;
    logic [TOT_W-1:0] possible_designs;
    logic [WAY_W-1:0] all_ways;
    logic             overflow;
  } result_t;

  // Stored pattern: byte 0 is the final character, byte j the one j places earlier.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    chars_t           chars;
  } row_t;

  typedef struct packed {
    logic valid;
    logic hit;
    way_t addend;
  } match_t;

  typedef struct packed {
    logic clr;
    logic add;
    logic fold;
  } accum_ctl_t;

endpackage

`default_nettype wire

// File: design/wbc_pattern_ram.sv
// Pattern table memory: one row per pattern, registered read.
`default_nettype none

module wbc_pattern_ram (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [wbc_pkg::ADDR_W-1:0] wr_addr,
  input  wire wbc_pkg::row_t             wr_row,
  input  wire logic                      rd_en,
  input  wire logic [wbc_pkg::ADDR_W-1:0] rd_addr,
  output wbc_pkg::row_t                  rd_row
);
  import wbc_pkg::*;

  row_t mem [MAX_PATTERNS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/wbc_match_unit.sv
// Compare stage: one stored pattern against the newest characters, registered.
`default_nettype none

module wbc_match_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic                      dup_mode,
  input  wire wbc_pkg::row_t             row,
  input  wire wbc_pkg::chars_t           window,
  input  wire logic [wbc_pkg::LEN_W-1:0]  ref_len,
  input  wire logic [wbc_pkg::DLEN_W-1:0] depth,
  input  wire wbc_pkg::hist_t            hist,
  output wbc_pkg::match_t                match
);
  import wbc_pkg::*;

  logic [MAX_PATTERN_LEN-1:0] byte_ok;
  logic                       chars_eq;
  logic                       len_ok;
  logic                       hit;
  logic [LIDX_W-1:0]          lidx;
  logic                       valid;
  logic                       hit_q;
  way_t                       addend;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
      byte_ok[j] = (LEN_W'(j) >= row.len) || (row.chars[j] == window[j]);
    end
    chars_eq = &byte_ok;
    if (dup_mode) begin
      len_ok = (row.len == ref_len);
    end else begin
      len_ok = (row.len != '0) && (CMP_W'(row.len) <= CMP_W'(depth));
    end
    hit  = chars_eq && len_ok;
    lidx = LIDX_W'(row.len - LEN_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    hit_q  <= hit;
    addend <= (hit && !dup_mode) ? hist[lidx] : '0;
  end

  assign match = '{valid: valid, hit: hit_q, addend: addend};

endmodule

`default_nettype wire

// File: design/wbc_accum.sv
// Shared saturating 63-bit adder with the running prefix-sum register.
`default_nettype none

module wbc_accum (
  input  wire logic                clk,
  input  wire wbc_pkg::accum_ctl_t ctl,
  input  wire wbc_pkg::way_t       addend,
  input  wire wbc_pkg::way_t       total,
  output wbc_pkg::way_t            sum,
  output wbc_pkg::way_t            fold_sum
);
  import wbc_pkg::*;

  way_t             opa;
  way_t             opb;
  logic [WAY_W:0]   raw;
  way_t             sat;

  always_comb begin
    opa = ctl.fold ? total : sum;
    opb = ctl.fold ? sum : addend;
    raw = {1'b0, opa} + {1'b0, opb};
    // Both operands stay below 2^63, so a carry out means saturate.
    sat = raw[WAY_W] ? '1 : raw[WAY_W-1:0];
  end

  assign fold_sum = sat;

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      sum <= '0;
    end else if (ctl.add) begin
      sum <= sat;
    end
  end

endmodule

`default_nettype wire

// File: design/word_break_way_counter.sv
// Top level of the word-break way counter: sequencer, history and totals.
`default_nettype none

// Word-break way counter. Words enter on item when start is high and busy is
// low. A pattern character without last is taken while busy stays low.
// Closing a pattern that is not overlong while the table has room scans the
// stored table for a duplicate, and each design character within the longest
// design length scans the table to add up the ways its prefix can end in a
// stored pattern; busy stays high during either scan, as the single read port
// of the pattern memory feeds one row per cycle through the compare stage and
// the shared saturating adder, and the next word enters only after the scan.
// At the last character of a design, result is shown with done high for
// exactly one cycle after the scan ends; the receiver cannot stall, so it
// must capture the word in that cycle. Overlong designs answer in the cycle
// after their last character with a zero count and overflow set.
module word_break_way_counter (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire wbc_pkg::item_t   item,
  output logic                  busy,
  output logic                  done,
  output wbc_pkg::result_t      result
);
  import wbc_pkg::*;

  // Sequencer and table bookkeeping
  state_t            state, state_next;
  logic [CNT_W-1:0]  k, k_next;
  logic              pend, pend_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              dup, dup_next;
  logic              item_last, item_last_next;

  // Pattern being loaded
  logic [LEN_W-1:0]  load_len, load_len_next;
  logic              load_overlong, load_overlong_next;
  chars_t            load_buf, load_buf_next;

  // Design in progress: newest characters and newest prefix way counts
  logic [DLEN_W-1:0] design_len, design_len_next;
  logic              design_overlong, design_overlong_next;
  chars_t            window, window_next;
  hist_t             hist, hist_next;

  // Totals since clear
  logic [TOT_W-1:0]  poss_total, poss_total_next;
  way_t              ways_total, ways_total_next;
  logic              ovf, ovf_next;

  logic              done_next;
  result_t           result_next;

  // Datapath connections
  logic              rd_en;
  logic              wr_en;
  row_t              rd_row;
  row_t              wr_row;
  match_t            match;
  accum_ctl_t        actl;
  way_t              acc_sum;
  way_t              acc_res;
  logic              scan_end;
  logic [TOT_W-1:0]  poss_inc;

  assign busy   = (state != ST_IDLE);
  assign wr_row = '{len: load_len, chars: load_buf};

  wbc_pattern_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_row  (wr_row),
    .rd_en   (rd_en),
    .rd_addr (k[ADDR_W-1:0]),
    .rd_row  (rd_row)
  );

  wbc_match_unit u_match (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pend),
    .dup_mode (state == ST_DUP),
    .row      (rd_row),
    .window   ((state == ST_DUP) ? load_buf : window),
    .ref_len  (load_len),
    .depth    (design_len),
    .hist     (hist),
    .match    (match)
  );

  wbc_accum u_accum (
    .clk      (clk),
    .ctl      (actl),
    .addend   (match.addend),
    .total    (ways_total),
    .sum      (acc_sum),
    .fold_sum (acc_res)
  );

  // Scan ends once every row has been read and has drained through compare and add.
  assign scan_end = (k == count) && !pend && !match.valid;
  assign poss_inc = ((acc_sum != '0) && (poss_total != '1)) ? poss_total + 1'b1 : poss_total;

  always_comb begin
    state_next           = state;
    k_next               = k;
    count_next           = count;
    dup_next             = dup;
    item_last_next       = item_last;
    load_len_next        = load_len;
    load_overlong_next   = load_overlong;
    load_buf_next        = load_buf;
    design_len_next      = design_len;
    design_overlong_next = design_overlong;
    window_next          = window;
    hist_next            = hist;
    poss_total_next      = poss_total;
    ways_total_next      = ways_total;
    ovf_next             = ovf;
    done_next            = 1'b0;
    result_next          = result;
    rd_en                = 1'b0;
    wr_en                = 1'b0;
    actl                 = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          case (item.cmd)
            CMD_PATTERN: begin
              // Shift the character in; drop it once the pattern is full.
              if (load_len < LEN_W'(MAX_PATTERN_LEN)) begin
                load_buf_next[0] = item.ch;
                for (int j = 1; j < MAX_PATTERN_LEN; j++) begin
                  load_buf_next[j] = load_buf[j-1];
                end
                load_len_next = load_len + 1'b1;
              end else begin
                load_overlong_next = 1'b1;
              end
              if (item.last) begin
                if (load_overlong_next || (count >= CNT_W'(MAX_PATTERNS))) begin
                  ovf_next           = 1'b1;
                  load_len_next      = '0;
                  load_overlong_next = 1'b0;
                end else begin
                  state_next = ST_DUP;
                  k_next     = '0;
                  dup_next   = 1'b0;
                end
              end
            end
            CMD_DESIGN: begin
              if (design_len < DLEN_W'(MAX_DESIGN_LEN)) begin
                window_next[0] = item.ch;
                for (int j = 1; j < MAX_PATTERN_LEN; j++) begin
                  window_next[j] = window[j-1];
                end
                // Empty prefix splits one way.
                if (design_len == '0) begin
                  hist_next[0] = WAY_W'(1);
                end
                design_len_next = design_len + 1'b1;
                item_last_next  = item.last;
                k_next          = '0;
                actl.clr        = 1'b1;
                state_next      = ST_SCAN;
              end else begin
                design_overlong_next = 1'b1;
                if (item.last) begin
                  ovf_next                     = 1'b1;
                  result_next.way_count        = '0;
                  result_next.possible         = 1'b0;
                  result_next.possible_designs = poss_total;
                  result_next.all_ways         = ways_total;
                  result_next.overflow         = 1'b1;
                  done_next                    = 1'b1;
                  design_len_next              = '0;
                  design_overlong_next         = 1'b0;
                end
              end
            end
            CMD_CLEAR: begin
              count_next           = '0;
              design_len_next      = '0;
              design_overlong_next = 1'b0;
              load_len_next        = '0;
              load_overlong_next   = 1'b0;
              poss_total_next      = '0;
              ways_total_next      = '0;
              ovf_next             = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        rd_en    = (k < count);
        actl.add = match.valid;
        if (rd_en) begin
          k_next = k + 1'b1;
        end
        if (scan_end) begin
          // Push the new prefix count into the history.
          hist_next[0] = acc_sum;
          for (int j = 1; j < MAX_PATTERN_LEN; j++) begin
            hist_next[j] = hist[j-1];
          end
          if (item_last) begin
            actl.fold                    = 1'b1;
            poss_total_next              = poss_inc;
            ways_total_next              = acc_res;
            result_next.way_count        = acc_sum;
            result_next.possible         = (acc_sum != '0);
            result_next.possible_designs = poss_inc;
            result_next.all_ways         = acc_res;
            result_next.overflow         = ovf;
            done_next                    = 1'b1;
            design_len_next              = '0;
            design_overlong_next         = 1'b0;
          end
          state_next = ST_IDLE;
        end
      end

      ST_DUP: begin
        rd_en = (k < count);
        if (rd_en) begin
          k_next = k + 1'b1;
        end
        if (match.valid && match.hit) begin
          dup_next = 1'b1;
        end
        if (scan_end) begin
          // Store only a pattern not already in the table.
          if (!dup) begin
            wr_en      = 1'b1;
            count_next = count + 1'b1;
          end
          load_len_next      = '0;
          load_overlong_next = 1'b0;
          state_next         = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    pend_next = rd_en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      k               <= '0;
      pend            <= 1'b0;
      count           <= '0;
      dup             <= 1'b0;
      item_last       <= 1'b0;
      load_len        <= '0;
      load_overlong   <= 1'b0;
      design_len      <= '0;
      design_overlong <= 1'b0;
      poss_total      <= '0;
      ways_total      <= '0;
      ovf             <= 1'b0;
      done            <= 1'b0;
    end else begin
      state           <= state_next;
      k               <= k_next;
      pend            <= pend_next;
      count           <= count_next;
      dup             <= dup_next;
      item_last       <= item_last_next;
      load_len        <= load_len_next;
      load_overlong   <= load_overlong_next;
      design_len      <= design_len_next;
      design_overlong <= design_overlong_next;
      poss_total      <= poss_total_next;
      ways_total      <= ways_total_next;
      ovf             <= ovf_next;
      done            <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    load_buf <= load_buf_next;
    window   <= window_next;
    hist     <= hist_next;
    result   <= result_next;
  end

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench of the word-break way counter: directed and random words.
module testbench;
  import wbc_pkg::*;

  // Stop the run here if the block ever hangs; a correct run needs far fewer cycles.
  localparam int CYCLE_LIMIT  = 1000000;
  // Long enough to wait out two full-table scans at the end.
  localparam int DRAIN_CYCLES = 2 * (MAX_PATTERNS + 3) + 10;
  localparam int SHOW_LIMIT   = 10;

  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    done;
  result_t result;

  word_break_way_counter u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // Mirror of the block: pattern table, design prefix counts and running totals.
  char_t            tbl_chars [MAX_PATTERNS][MAX_PATTERN_LEN];
  int unsigned      tbl_len [MAX_PATTERNS];
  int unsigned      tbl_count;
  int unsigned      load_len;
  bit               load_long;
  char_t            dsg_chars [MAX_DESIGN_LEN];
  way_t             dsg_ways [MAX_DESIGN_LEN+1];
  int unsigned      dsg_len;
  bit               dsg_long;
  logic [TOT_W-1:0] tot_possible;
  way_t             tot_ways;
  bit               ovf_seen;

  // Counts the block still owes, oldest first.
  result_t          way_results_due[$];

  int unsigned      mismatches;
  int unsigned      words_sent;
  int unsigned      cycles;
  bit               gaps_on;
  char_t            alphabet [3];
  char_t            text_buf[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: a hung handshake or a missing result ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic way_t sat_add_ways(way_t a, way_t b);
    logic [WAY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WAY_W] ? {WAY_W{1'b1}} : s[WAY_W-1:0];
  endfunction

  // Empty the table, zero the totals and the sticky overflow, drop any work in flight.
  function automatic void forget_all();
    foreach (tbl_len[k]) tbl_len[k] = 0;
    tbl_count    = 0;
    load_len     = 0;
    load_long    = 1'b0;
    dsg_len      = 0;
    dsg_long     = 1'b0;
    tot_possible = '0;
    tot_ways     = '0;
    ovf_seen     = 1'b0;
  endfunction

  // Grow the pattern in the next free slot; on its last character either store it,
  // drop it as a duplicate, or drop it and flag overflow (too long or table full).
  function automatic void take_pattern_char(char_t c, logic fin);
    bit dup;
    bit same;
    if (load_len < MAX_PATTERN_LEN) begin
      if (tbl_count < MAX_PATTERNS) tbl_chars[tbl_count][load_len] = c;
      load_len++;
    end else begin
      load_long = 1'b1;
    end
    if (!fin) return;
    if (load_long || tbl_count >= MAX_PATTERNS) begin
      ovf_seen = 1'b1;
    end else begin
      dup = 1'b0;
      for (int k = 0; k < tbl_count; k++) begin
        same = (tbl_len[k] == load_len);
        for (int i = 0; same && i < load_len; i++)
          if (tbl_chars[k][i] != tbl_chars[tbl_count][i]) same = 1'b0;
        if (same) dup = 1'b1;
      end
      if (!dup) begin
        tbl_len[tbl_count] = load_len;
        tbl_count++;
      end
    end
    load_len  = 0;
    load_long = 1'b0;
  endfunction

  // Extend the design by one character and add up the ways its new prefix can end
  // in a stored pattern, against the table as it stands right now.
  function automatic void take_design_char(char_t c);
    way_t        sum;
    int unsigned n;
    int unsigned len;
    bit          hit;
    if (dsg_len >= MAX_DESIGN_LEN) begin
      dsg_long = 1'b1;
      return;
    end
    if (dsg_len == 0) dsg_ways[0] = 1;
    dsg_chars[dsg_len] = c;
    dsg_len++;
    n   = dsg_len;
    sum = '0;
    for (int k = 0; k < tbl_count; k++) begin
      len = tbl_len[k];
      hit = (len >= 1 && len <= n);
      for (int i = 0; hit && i < len; i++)
        if (tbl_chars[k][i] != dsg_chars[n - len + i]) hit = 1'b0;
      if (hit) sum = sat_add_ways(sum, dsg_ways[n - len]);
    end
    dsg_ways[n] = sum;
  endfunction

  // Advance the mirror by one accepted word; queue a count when a design closes.
  function automatic void predict_word(item_t w);
    result_t r;
    way_t    cnt;
    case (w.cmd)
      CMD_PATTERN: take_pattern_char(w.ch, w.last);
      CMD_CLEAR:   forget_all();
      CMD_DESIGN: begin
        take_design_char(w.ch);
        if (w.last) begin
          cnt = '0;
          if (dsg_long) begin
            ovf_seen = 1'b1;
          end else begin
            cnt = dsg_ways[dsg_len];
            if (cnt != '0 && tot_possible != {TOT_W{1'b1}}) tot_possible++;
            tot_ways = sat_add_ways(tot_ways, cnt);
          end
          dsg_len  = 0;
          dsg_long = 1'b0;
          r.way_count        = cnt;
          r.possible         = (cnt != '0);
          r.possible_designs = tot_possible;
          r.all_ways         = tot_ways;
          r.overflow         = ovf_seen;
          way_results_due.insert(way_results_due.size(), r);
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result check: done is a one-cycle strobe, so take the word at this very edge.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (way_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("unexpected result: ways=%0d possible=%0b designs=%0d total=%0d ovf=%0b",
                   result.way_count, result.possible, result.possible_designs,
                   result.all_ways, result.overflow);
      end else begin
        want = way_results_due.pop_front();
        if (result.way_count !== want.way_count || result.possible !== want.possible ||
            result.possible_designs !== want.possible_designs ||
            result.all_ways !== want.all_ways || result.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT) begin
            $display("mismatch: expected ways=%0d possible=%0b designs=%0d total=%0d ovf=%0b",
                     want.way_count, want.possible, want.possible_designs,
                     want.all_ways, want.overflow);
            $display("          got      ways=%0d possible=%0b designs=%0d total=%0d ovf=%0b",
                     result.way_count, result.possible, result.possible_designs,
                     result.all_ways, result.overflow);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one word: maybe idle a burst first, then hold start until busy is low at
  // a rising edge. Drive on the falling edge so the block sees stable inputs.
  task automatic send_word(cmd_t c, char_t ch, logic fin);
    item_t w;
    w.cmd  = c;
    w.ch   = ch;
    w.last = fin;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      start   <= 1'b0;
      item.ch <= 8'($urandom);
      repeat ($urandom_range(1, 14) - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_word(w);
    if (c != CMD_NONE) words_sent++;
  endtask

  // Send the buffered string as one pattern or design, last on the final character.
  task automatic send_text(cmd_t c);
    foreach (text_buf[i]) send_word(c, text_buf[i], i == text_buf.size() - 1);
  endtask

  // Append one character to the text buffer.
  function automatic void add_char(char_t c);
    text_buf.insert(text_buf.size(), c);
  endfunction

  function automatic void pick_alphabet();
    foreach (alphabet[i]) alphabet[i] = 8'($urandom);
  endfunction

  // Mostly a small alphabet so patterns meet designs; now and then any byte.
  function automatic char_t pick_char();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom) : alphabet[$urandom_range(0, 2)];
  endfunction

  function automatic void fill_random(int unsigned n);
    text_buf.delete();
    repeat (n) add_char(pick_char());
  endfunction

  // Build a design out of stored patterns so it has at least one split.
  function automatic void fill_composed(int unsigned parts);
    int unsigned k;
    text_buf.delete();
    repeat (parts) begin
      k = $urandom_range(0, tbl_count - 1);
      for (int i = 0; i < tbl_len[k]; i++) add_char(tbl_chars[k][i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty table, byte extremes, every command, ignored command, clear.
  task automatic test_basic_ops();
    send_word(CMD_DESIGN, 8'h00, 1'b1);
    send_word(CMD_PATTERN, 8'h00, 1'b1);
    send_word(CMD_PATTERN, 8'hFF, 1'b1);
    text_buf = {8'h00, 8'hFF};
    send_text(CMD_PATTERN);
    send_word(CMD_NONE, 8'hFF, 1'b1);
    send_word(CMD_NONE, 8'h00, 1'b0);
    text_buf = {8'h00, 8'hFF, 8'h00, 8'hFF};
    send_text(CMD_DESIGN);
    send_word(CMD_DESIGN, 8'h7F, 1'b1);
    send_word(CMD_CLEAR, 8'hFF, 1'b1);
    send_word(CMD_DESIGN, 8'hFF, 1'b1);
  endtask

  // Repeat patterns: the table keeps each string once.
  task automatic test_duplicates();
    send_word(CMD_CLEAR, 8'h00, 1'b0);
    text_buf = {8'h61, 8'h62};
    send_text(CMD_PATTERN);
    send_text(CMD_PATTERN);
    send_word(CMD_PATTERN, 8'h61, 1'b1);
    send_word(CMD_PATTERN, 8'h62, 1'b1);
    send_word(CMD_PATTERN, 8'h61, 1'b1);
    text_buf = {8'h61, 8'h62};
    send_text(CMD_DESIGN);
  endtask

  // A pattern of exactly the longest length stays; one character more is dropped.
  task automatic test_overlong_pattern();
    send_word(CMD_CLEAR, 8'h00, 1'b1);
    text_buf.delete();
    for (int i = 0; i < MAX_PATTERN_LEN; i++) add_char(8'(8'h10 + i));
    send_text(CMD_PATTERN);
    send_text(CMD_DESIGN);
    text_buf.delete();
    for (int i = 0; i <= MAX_PATTERN_LEN; i++) add_char(8'(8'h20 + i));
    send_text(CMD_PATTERN);
    void'(text_buf.pop_back());
    send_text(CMD_DESIGN);
  endtask

  // Clear in the middle of a pattern and of a design abandons both.
  task automatic test_clear_midway();
    send_word(CMD_PATTERN, 8'h70, 1'b0);
    send_word(CMD_PATTERN, 8'h71, 1'b0);
    send_word(CMD_CLEAR, 8'h00, 1'b0);
    send_word(CMD_PATTERN, 8'h72, 1'b1);
    send_word(CMD_DESIGN, 8'h64, 1'b0);
    send_word(CMD_DESIGN, 8'h64, 1'b0);
    send_word(CMD_CLEAR, 8'h00, 1'b1);
    send_word(CMD_PATTERN, 8'h72, 1'b1);
    send_word(CMD_DESIGN, 8'h72, 1'b1);
  endtask

  // Load patterns while a design is open: each character sees the table of its time.
  task automatic test_table_change();
    send_word(CMD_CLEAR, 8'h00, 1'b0);
    send_word(CMD_PATTERN, 8'h61, 1'b1);
    send_word(CMD_DESIGN, 8'h61, 1'b0);
    send_word(CMD_PATTERN, 8'h62, 1'b1);
    send_word(CMD_DESIGN, 8'h62, 1'b1);
    send_word(CMD_DESIGN, 8'h63, 1'b0);
    send_word(CMD_PATTERN, 8'h63, 1'b1);
    send_word(CMD_DESIGN, 8'h63, 1'b1);
  endtask

  // Fill all slots, bounce a copy and a fresh pattern off the full table, then
  // run designs against every row.
  task automatic test_full_table();
    send_word(CMD_CLEAR, 8'h00, 1'b0);
    for (int k = 0; k < MAX_PATTERNS; k++) begin
      text_buf.delete();
      add_char(8'(4 * k + 3));
      repeat (k % 3) add_char(8'($urandom));
      send_text(CMD_PATTERN);
    end
    text_buf = {8'h03};
    send_text(CMD_PATTERN);
    text_buf = {8'h00, 8'h01};
    send_text(CMD_PATTERN);
    repeat (6) begin
      fill_composed($urandom_range(1, 4));
      send_text(CMD_DESIGN);
    end
  endtask

  // Runs of one letter with patterns of every length give huge counts; the sum of
  // the ways of three longest designs pins all_ways at its top.
  task automatic test_saturation();
    send_word(CMD_CLEAR, 8'hFF, 1'b1);
    for (int len = 1; len <= MAX_PATTERN_LEN; len++) begin
      text_buf.delete();
      repeat (len) add_char(8'h61);
      send_text(CMD_PATTERN);
    end
    text_buf.delete();
    repeat (MAX_DESIGN_LEN) add_char(8'h61);
    repeat (3) send_text(CMD_DESIGN);
  endtask

  // Design past the longest length: zero count, totals held, overflow sticks
  // until a clear.
  task automatic test_overlong_design();
    text_buf.delete();
    repeat (MAX_DESIGN_LEN + 6) add_char(8'h61);
    send_text(CMD_DESIGN);
    text_buf = {8'h61, 8'h61};
    send_text(CMD_DESIGN);
    send_word(CMD_CLEAR, 8'h00, 1'b0);
    send_word(CMD_DESIGN, 8'h61, 1'b1);
  endtask

  // Mostly well-formed traffic: patterns over a small alphabet and designs built
  // from them, with noise, broken words, clears and the odd overlong string mixed in.
  task automatic test_random(int unsigned target);
    int unsigned roll;
    int unsigned n;
    while (words_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_word(CMD_CLEAR, 8'($urandom), 1'($urandom));
        pick_alphabet();
      end else if (roll < 8) begin
        send_word(CMD_NONE, 8'($urandom), 1'($urandom));
      end else if (roll < 30 || tbl_count == 0) begin
        if ($urandom_range(0, 19) == 0) n = $urandom_range(MAX_PATTERN_LEN + 1, 11);
        else if ($urandom_range(0, 3) == 0) n = $urandom_range(4, MAX_PATTERN_LEN);
        else n = $urandom_range(1, 3);
        fill_random(n);
        send_text(CMD_PATTERN);
      end else if (roll < 38) begin
        fill_random($urandom_range(1, 10));
        send_text(CMD_DESIGN);
      end else if (roll < 42) begin
        // broken words: characters of either kind with no closing last
        fill_random($urandom_range(1, 5));
        foreach (text_buf[i])
          send_word($urandom_range(0, 1) ? CMD_DESIGN : CMD_PATTERN, text_buf[i], 1'b0);
      end else if (roll < 43) begin
        fill_random($urandom_range(MAX_DESIGN_LEN + 1, MAX_DESIGN_LEN + 6));
        send_text(CMD_DESIGN);
      end else begin
        fill_composed($urandom_range(1, 6));
        if ($urandom_range(0, 7) == 0) add_char(pick_char());
        send_text(CMD_DESIGN);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    item       = '0;
    gaps_on    = 1'b1;
    mismatches = 0;
    words_sent = 0;
    forget_all();
    pick_alphabet();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_duplicates();
    test_overlong_pattern();
    test_clear_midway();
    test_table_change();
    test_full_table();
    test_saturation();
    test_overlong_design();
    test_random(words_sent + 200);
    // last stretch: back-to-back words, no idling
    gaps_on = 1'b0;
    test_random(words_sent + 60);

    @(negedge clk);
    start <= 1'b0;
    while (way_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && way_results_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: word_break_way_counter.f
design/wbc_pkg.sv
design/wbc_pattern_ram.sv
design/wbc_match_unit.sv
design/wbc_accum.sv
design/word_break_way_counter.sv
bench/testbench.sv
